// ----- sv/tbps_pkg.sv -----
// shared types, constants and codes of the token bucket packet shaper
package tbps_pkg;

    // widths of the request and result fields
    localparam int NEED_W = 16;
    localparam int SVC_W  = 24;
    localparam int ID_W   = 32;
    localparam int LVL_W  = 16;

    // defaults and fixed values
    localparam int                QUEUE_DEPTH_DEF  = 16;
    localparam logic [LVL_W-1:0]  DEPTH_RESET      = 16'd10;
    localparam logic [SVC_W-1:0]  SERVICE_MAX      = 24'd10000000;
    localparam logic [ID_W-1:0]   FIRST_ID         = 32'd1;

    // request kinds
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ENQ       = 3'd0,
        KIND_DROP_BIG  = 3'd1,
        KIND_DROP_FULL = 3'd2,
        KIND_TOK_ADD   = 3'd3,
        KIND_TOK_DROP  = 3'd4,
        KIND_RELEASE   = 3'd5
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_CHECK
    } t_state;

    // one waiting packet
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NEED_W-1:0] need;
        logic [SVC_W-1:0]  svc;
    } t_entry;

    // flags from the shared compare and subtract unit
    typedef struct packed {
        logic             ge;
        logic [LVL_W-1:0] diff;
    } t_alu_res;

endpackage

// ----- sv/tbps_req_if.sv -----
// request channel: packet arrivals and token ticks
interface tbps_req_if;
    import tbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [NEED_W-1:0] tokens_needed;
    logic [SVC_W-1:0]  service_us;

    modport source (output valid, req_type, tokens_needed, service_us, input ready);
    modport sink   (input valid, req_type, tokens_needed, service_us, output ready);
endinterface

// ----- sv/tbps_res_if.sv -----
// result channel: status and release results of the shaper
interface tbps_res_if #(
    parameter int CNT_W = 5
);
    import tbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [ID_W-1:0]   packet_id;
    logic [NEED_W-1:0] need_out;
    logic [SVC_W-1:0]  service_out;
    logic [LVL_W-1:0]  bucket_now;
    logic [CNT_W-1:0]  queue_count;
    logic              last;

    modport source (output valid, event_kind, packet_id, need_out, service_out,
                    bucket_now, queue_count, last, input ready);
    modport sink   (input valid, event_kind, packet_id, need_out, service_out,
                    bucket_now, queue_count, last, output ready);
endinterface

// ----- sv/tbps_alu.sv -----
// shared compare and subtract unit: a >= b and a - b
module tbps_alu
    import tbps_pkg::*;
(
    input  logic [LVL_W-1:0] i_a,
    input  logic [LVL_W-1:0] i_b,
    output t_alu_res         o_res
);
    logic [LVL_W:0] w_sub;

    // one extra bit catches the borrow
    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_sub[LVL_W];
    assign o_res.diff = w_sub[LVL_W-1:0];
endmodule

// ----- sv/tbps_queue.sv -----
// waiting packet store: one write port at the tail, registered read at the head
module tbps_queue
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH)
)(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output t_entry           o_rdata
);
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    // write at tail
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read at head
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/token_bucket_packet_shaper.sv -----
// token bucket packet shaper, top level with event sequencer
// the first result is registered out of the check state after the eval and read
// states, once the output is free; each release keeps the block busy for one
// more read and check, set by the shared compare unit and registered head read
// reset (synchronous, active low) empties the queue, zeroes the bucket, sets
// the next id to 1 and the depth to 10; queue storage is not cleared
module token_bucket_packet_shaper
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tbps_req_if.sink          i_req,
    tbps_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [LVL_W-1:0]  i_cfg_data
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [NEED_W-1:0] need;
        logic [SVC_W-1:0]  svc;
        logic [LVL_W-1:0]  level;
        logic [CNT_W-1:0]  count;
    } t_result;

    t_state            r_state, n_state;
    logic [LVL_W-1:0]  r_depth;
    logic [LVL_W-1:0]  r_level, n_level;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_in_type;
    logic [NEED_W-1:0] r_in_need;
    logic [SVC_W-1:0]  r_in_svc;
    t_result           r_pend, n_pend;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              r_out_last, n_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic              w_release;
    logic              w_we;
    logic [SVC_W-1:0]  w_svc_clamp;
    logic [LVL_W-1:0]  w_alu_a, w_alu_b;
    t_alu_res          w_alu;
    t_entry            w_wdata;
    t_entry            w_head;

    assign w_accept   = i_req.valid & i_req.ready;
    assign w_out_free = ~r_out_valid | o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // clamp of the service time
    assign w_svc_clamp = (r_in_svc > SERVICE_MAX) ? SERVICE_MAX : r_in_svc;
    assign w_wdata     = '{id: r_next_id, need: r_in_need, svc: w_svc_clamp};

    // head release test
    assign w_release = (r_count != '0) & w_alu.ge;

    // operand selection for the shared unit
    always_comb begin
        w_alu_a = r_level;
        w_alu_b = r_depth;
        if (r_state == ST_EVAL && r_in_type == REQ_ARRIVAL) begin
            w_alu_a = r_depth;
            w_alu_b = r_in_need;
        end else if (r_state == ST_CHECK) begin
            w_alu_a = r_level;
            w_alu_b = w_head.need;
        end
    end

    tbps_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    tbps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_wdata),
        .i_raddr (r_head),
        .o_rdata (w_head)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) begin
                n_state = ST_EVAL;
            end
            ST_EVAL:  n_state = ST_READ;
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: if (w_out_free) begin
                n_state = w_release ? ST_READ : ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath updates per state
    always_comb begin
        n_level     = r_level;
        n_next_id   = r_next_id;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid & ~o_res.ready;
        w_we        = 1'b0;
        unique case (r_state)
            ST_EVAL: begin
                if (r_in_type == REQ_ARRIVAL) begin
                    n_next_id  = r_next_id + 1'b1;
                    n_pend.id   = r_next_id;
                    n_pend.need = r_in_need;
                    n_pend.svc  = w_svc_clamp;
                    if (!w_alu.ge) begin
                        n_pend.kind = KIND_DROP_BIG;
                    end else if (r_count == CNT_FULL) begin
                        n_pend.kind = KIND_DROP_FULL;
                    end else begin
                        n_pend.kind = KIND_ENQ;
                        w_we        = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_tail      = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    end
                end else begin
                    n_pend.id   = '0;
                    n_pend.need = '0;
                    n_pend.svc  = '0;
                    if (!w_alu.ge) begin
                        n_pend.kind = KIND_TOK_ADD;
                        n_level     = r_level + 1'b1;
                    end else begin
                        n_pend.kind = KIND_TOK_DROP;
                    end
                end
                n_pend.level = n_level;
                n_pend.count = n_count;
            end
            ST_CHECK: begin
                if (w_out_free) begin
                    // pending result leaves, last unless a release follows
                    n_out       = r_pend;
                    n_out_last  = ~w_release;
                    n_out_valid = 1'b1;
                    if (w_release) begin
                        n_level      = w_alu.diff;
                        n_count      = r_count - 1'b1;
                        n_head       = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                        n_pend.kind  = KIND_RELEASE;
                        n_pend.id    = w_head.id;
                        n_pend.need  = w_head.need;
                        n_pend.svc   = w_head.svc;
                        n_pend.level = w_alu.diff;
                        n_pend.count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= DEPTH_RESET;
            r_level     <= '0;
            r_next_id   <= FIRST_ID;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_next_id   <= n_next_id;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_depth <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_type <= i_req.req_type;
            r_in_need <= i_req.tokens_needed;
            r_in_svc  <= i_req.service_us;
        end
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // result channel
    assign o_res.valid       = r_out_valid;
    assign o_res.event_kind  = r_out.kind;
    assign o_res.packet_id   = r_out.id;
    assign o_res.need_out    = r_out.need;
    assign o_res.service_out = r_out.svc;
    assign o_res.bucket_now  = r_out.level;
    assign o_res.queue_count = r_out.count;
    assign o_res.last        = r_out_last;
endmodule

// ----- sv/tbps_checker.sv -----
// port level checks of the shaper and their binding to the top level
module tbps_checker
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [2:0]        i_kind,
    input logic [ID_W-1:0]   i_id,
    input logic [NEED_W-1:0] i_need,
    input logic [SVC_W-1:0]  i_svc,
    input logic [CNT_W-1:0]  i_count,
    input logic              i_last
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_id) && $stable(i_last))
        else $error("stalled result changed");

    // no new request while one is at work
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // token results carry no packet
    a_token_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_TOK_ADD || i_kind == KIND_TOK_DROP)
            |-> i_id == '0 && i_need == '0 && i_svc == '0)
        else $error("token result with packet fields");

    // service time stays clamped
    a_svc_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_svc <= SERVICE_MAX)
        else $error("service time above limit");

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
endmodule

bind token_bucket_packet_shaper tbps_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
) u_tbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.event_kind),
    .i_id        (o_res.packet_id),
    .i_need      (o_res.need_out),
    .i_svc       (o_res.service_out),
    .i_count     (o_res.queue_count),
    .i_last      (o_res.last)
);
